@@ hw/rtl/gammatone_baseband_cascade_filter_macros.svh @@
// Assertion macros used by the filter RTL
`ifndef GAMMATONE_BASEBAND_CASCADE_FILTER_MACROS_SVH
`define GAMMATONE_BASEBAND_CASCADE_FILTER_MACROS_SVH

// assert that a condition implies another in the same cycle
`define GBC_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// assert that a condition implies another in the next cycle
`define GBC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

@@ hw/rtl/gbc_pkg.sv @@
// ----------------------------------------------------------------------------
// gbc_pkg
// Constants, types and the sine/cosine lookup function of the gammatone filter.
// ----------------------------------------------------------------------------
package gbc_pkg;

    localparam int STAGES      = 4;
    localparam int STATE_W     = 24;
    localparam int PHASE_W     = 24;
    localparam int TABLE_DEPTH = 1024;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int OUT_W       = 24;
    localparam int TRIG_W      = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int STAGE_AW    = (STAGES > 1) ? $clog2(STAGES) : 1;
    // product width for state * coefficient or state * trig
    localparam int PROD_W      = STATE_W + 1 + COEF_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_RE,
        ST_MIX_IM,
        ST_STAGE_RE,
        ST_STAGE_IM,
        ST_OUT_A,
        ST_OUT_B,
        ST_DONE
    } state_t;

    typedef logic signed [TRIG_W-1:0] trig_t;

    typedef struct packed {
        logic                       start;
        logic signed [STATE_W:0]    mcand;
        logic signed [COEF_W:0]     mplier;
    } mul_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [PROD_W-1:0]   prod;
    } mul_rsp_t;

    function automatic logic signed [31:0] quarter_sine(input longint x);
        longint x2;
        longint t;
        longint r;
        x2 = (x * x) >>> 16;
        t = 64'sd4858603;
        t = 64'sd85569278 - ((t * x2) >>> 16);
        t = 64'sd693598564 - ((t * x2) >>> 16);
        t = 64'sd1686629713 - ((t * x2) >>> 16);
        r = (t * x) >>> 16;
        r = (r + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < 0) r = 0;
        return 32'(r);
    endfunction

    // sin when want_cos is 0, cos otherwise
    function automatic trig_t trig_lookup(input logic [TABLE_AW-1:0] j, input logic want_cos);
        longint q;
        longint x;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] s;
        logic signed [31:0] c;
        q = (longint'(j) * 4) / TABLE_DEPTH;
        x = ((longint'(j) * 4 - q * TABLE_DEPTH) * 65536) / TABLE_DEPTH;
        a = quarter_sine(x);
        b = quarter_sine(65536 - x);
        unique case (q[1:0])
            2'd0:    begin s = a;  c = b;  end
            2'd1:    begin s = b;  c = -a; end
            2'd2:    begin s = -a; c = -b; end
            default: begin s = -b; c = a;  end
        endcase
        return want_cos ? trig_t'(c) : trig_t'(s);
    endfunction

endpackage

@@ hw/rtl/gbc_if.sv @@
// ----------------------------------------------------------------------------
// gbc_if
// Valid/ready channels of the gammatone filter.
// ----------------------------------------------------------------------------
interface gbc_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  sample;
    logic                first_sample;
    modport source (output valid, sample, first_sample, input ready);
    modport sink (input valid, sample, first_sample, output ready);
endinterface

interface gbc_out_if;
    logic                valid;
    logic                ready;
    logic signed [23:0]  filtered;
    modport source (output valid, filtered, input ready);
    modport sink (input valid, filtered, output ready);
endinterface

interface gbc_cfg_if;
    logic         valid;
    logic         ready;
    logic [0:0]   index;
    logic [23:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hw/rtl/gammatone_baseband_cascade_filter.sv @@
// ----------------------------------------------------------------------------
// gammatone_baseband_cascade_filter
// Complex baseband gammatone filter: mix down, cascade of one-pole stages,
// mix back up, emit the saturated real part.
// ----------------------------------------------------------------------------
// channel  dir  payload                      handshake
// in_ch    in   sample[16], first_sample     valid/ready
// out_ch   out  filtered[24]                 valid/ready
// cfg      in   index[1], data[24]           valid/ready
//
// Each item takes 2*(STAGES+2) serial multiplies, each a start, 17 shift-add
// steps and a result, plus the accept and write-out steps; the bit-serial
// multiplier dominates. A new item is taken only once the previous one has
// been written to the output register. An item may be taken while the
// previous result still waits in the output register; a stalled output
// holds the finished item in the last state and blocks the next input.
// Reset clears control, config, state and phase.
// ----------------------------------------------------------------------------
`include "gammatone_baseband_cascade_filter_macros.svh"

module gammatone_baseband_cascade_filter (
    input  logic      clk,
    input  logic      rst_n,
    gbc_in_if.sink    in_ch,
    gbc_out_if.source out_ch,
    gbc_cfg_if.sink   cfg
);
    import gbc_pkg::*;

    localparam logic signed [STATE_W-1:0] SMAX = {1'b0, {(STATE_W-1){1'b1}}};
    localparam logic signed [STATE_W-1:0] SMIN = {1'b1, {(STATE_W-1){1'b0}}};

    state_t state_reg, state_next;

    logic [COEF_W-1:0]         coef_reg;
    logic [PHASE_W-1:0]        step_reg;
    logic [PHASE_W-1:0]        phase_reg;
    logic signed [STATE_W-1:0] sr_reg [STAGES];
    logic signed [STATE_W-1:0] si_reg [STAGES];
    logic signed [STATE_W-1:0] mr_prev_reg, mi_prev_reg;
    logic signed [STATE_W-1:0] mr_reg, mi_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    trig_t                     cos_reg, sin_reg;
    logic [STAGE_AW-1:0]       stage_reg;
    logic                      issued_reg;
    logic signed [PROD_W-1:0]  ya_reg;
    logic signed [OUT_W-1:0]   out_reg;
    logic                      out_valid_reg;

    trig_t                     cos_rom [TABLE_DEPTH];
    trig_t                     sin_rom [TABLE_DEPTH];

    mul_req_t req;
    mul_rsp_t rsp;

    logic                      accept_in;
    logic                      out_load;
    logic                      stage_last;
    logic [TABLE_AW-1:0]       tidx;
    logic [TABLE_AW-1:0]       rom_addr;
    logic signed [STATE_W-1:0] cur_w, prev_z, diff_src;
    logic signed [STATE_W:0]   diff;
    logic signed [PROD_W-1:0]  rnd16, rnd15, ysum, yrnd;
    logic signed [STATE_W+1:0] upd;
    logic signed [STATE_W-1:0] upd_sat;
    logic signed [PROD_W-1:0]  mix_rnd;
    logic signed [STATE_W-1:0] mix_sat;

    gbc_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // constant sine and cosine tables
    initial
    begin
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            cos_rom[j] = trig_lookup(TABLE_AW'(j), 1'b1);
            sin_rom[j] = trig_lookup(TABLE_AW'(j), 1'b0);
        end
    end

    assign accept_in  = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign cfg.ready   = 1'b1;
    assign out_ch.valid    = out_valid_reg;
    assign out_ch.filtered = out_reg;
    assign out_load   = (state_reg == ST_DONE) && !out_valid_reg;
    assign stage_last = (stage_reg == STAGE_AW'(0));
    assign tidx = phase_reg[PHASE_W-1 -: TABLE_AW];
    // a first sample starts from phase zero
    assign rom_addr = in_ch.first_sample ? '0 : tidx;

    // stage operands: stages run from last down to first
    always_comb
    begin
        cur_w  = (state_reg == ST_STAGE_IM) ? si_reg[stage_reg] : sr_reg[stage_reg];
        if (stage_reg == STAGE_AW'(0))
            prev_z = (state_reg == ST_STAGE_IM) ? mi_prev_reg : mr_prev_reg;
        else
            prev_z = (state_reg == ST_STAGE_IM) ? si_reg[stage_reg - 1'b1]
                                                 : sr_reg[stage_reg - 1'b1];
        diff_src = prev_z;
        diff   = (STATE_W+1)'(diff_src) - (STATE_W+1)'(cur_w);
        rnd16  = (rsp.prod + (PROD_W'(1) <<< 15)) >>> 16;
        upd    = (STATE_W+2)'(cur_w) + (STATE_W+2)'(rnd16);
        if (upd > (STATE_W+2)'(SMAX))
            upd_sat = SMAX;
        else if (upd < (STATE_W+2)'(SMIN))
            upd_sat = SMIN;
        else
            upd_sat = upd[STATE_W-1:0];
        rnd15   = (rsp.prod + (PROD_W'(1) <<< 14)) >>> 15;
        mix_rnd = (state_reg == ST_MIX_IM) ? -rnd15 : rnd15;
        if (mix_rnd > PROD_W'(SMAX))
            mix_sat = SMAX;
        else if (mix_rnd < PROD_W'(SMIN))
            mix_sat = SMIN;
        else
            mix_sat = mix_rnd[STATE_W-1:0];
        // the multiplier holds its last product while the result waits
        ysum = ya_reg - rsp.prod;
        yrnd = (ysum + (PROD_W'(1) <<< 14)) >>> 15;
    end

    // multiplier operands for each state
    always_comb
    begin
        req.start  = 1'b0;
        req.mcand  = '0;
        req.mplier = '0;
        unique case (state_reg)
            ST_MIX_RE:
            begin
                req.mcand  = (STATE_W+1)'(x_reg);
                req.mplier = (COEF_W+1)'(cos_reg);
            end
            ST_MIX_IM:
            begin
                req.mcand  = (STATE_W+1)'(x_reg);
                req.mplier = (COEF_W+1)'(sin_reg);
            end
            ST_STAGE_RE, ST_STAGE_IM:
            begin
                req.mcand  = diff;
                req.mplier = {1'b0, coef_reg};
            end
            ST_OUT_A:
            begin
                req.mcand  = (STATE_W+1)'(sr_reg[STAGES-1]);
                req.mplier = (COEF_W+1)'(cos_reg);
            end
            ST_OUT_B:
            begin
                req.mcand  = (STATE_W+1)'(si_reg[STAGES-1]);
                req.mplier = (COEF_W+1)'(sin_reg);
            end
            default:
            begin
                req.mcand  = '0;
            end
        endcase
        req.start = (state_reg != ST_IDLE) && (state_reg != ST_DONE) && !issued_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (accept_in) state_next = ST_MIX_RE;
            ST_MIX_RE:   if (rsp.done) state_next = ST_MIX_IM;
            ST_MIX_IM:   if (rsp.done) state_next = ST_STAGE_RE;
            ST_STAGE_RE: if (rsp.done) state_next = ST_STAGE_IM;
            ST_STAGE_IM: if (rsp.done) state_next = stage_last ? ST_OUT_A : ST_STAGE_RE;
            ST_OUT_A:    if (rsp.done) state_next = ST_OUT_B;
            ST_OUT_B:    if (rsp.done) state_next = ST_DONE;
            ST_DONE:     if (!out_valid_reg) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            coef_reg      <= '0;
            step_reg      <= '0;
            phase_reg     <= '0;
            mr_prev_reg   <= '0;
            mi_prev_reg   <= '0;
            stage_reg     <= '0;
            for (int k = 0; k < STAGES; k++)
            begin
                sr_reg[k] <= '0;
                si_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (req.start)
                issued_reg <= 1'b1;
            else if (rsp.done)
                issued_reg <= 1'b0;
            if (out_ch.valid && out_ch.ready)
                out_valid_reg <= 1'b0;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_reg + step_reg;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_SMOOTHING)
                    coef_reg <= cfg.data[COEF_W-1:0];
                else
                    step_reg <= cfg.data[PHASE_W-1:0];
            end
            if (accept_in)
            begin
                stage_reg <= STAGE_AW'(STAGES - 1);
                if (in_ch.first_sample)
                begin
                    // clear history and phase before this item
                    phase_reg   <= '0;
                    mr_prev_reg <= '0;
                    mi_prev_reg <= '0;
                    for (int k = 0; k < STAGES; k++)
                    begin
                        sr_reg[k] <= '0;
                        si_reg[k] <= '0;
                    end
                end
            end
            if (rsp.done)
            begin
                unique case (state_reg)
                    ST_STAGE_RE: sr_reg[stage_reg] <= upd_sat;
                    ST_STAGE_IM:
                    begin
                        si_reg[stage_reg] <= upd_sat;
                        if (stage_last)
                        begin
                            mr_prev_reg <= mr_reg;
                            mi_prev_reg <= mi_reg;
                        end
                        else
                            stage_reg <= stage_reg - 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            x_reg   <= in_ch.sample;
            cos_reg <= cos_rom[rom_addr];
            sin_reg <= sin_rom[rom_addr];
        end
        if (rsp.done && state_reg == ST_MIX_RE)
            mr_reg <= mix_sat;
        if (rsp.done && state_reg == ST_MIX_IM)
            mi_reg <= mix_sat;
        if (rsp.done && state_reg == ST_OUT_A)
            ya_reg <= rsp.prod;
        if (out_load)
        begin
            if (yrnd > PROD_W'((1 <<< (OUT_W-1)) - 1))
                out_reg <= {1'b0, {(OUT_W-1){1'b1}}};
            else if (yrnd < -PROD_W'(1 <<< (OUT_W-1)))
                out_reg <= {1'b1, {(OUT_W-1){1'b0}}};
            else
                out_reg <= yrnd[OUT_W-1:0];
        end
    end

    `GBC_ASSERT_IMPLY(a_no_accept_busy, clk, rst_n, accept_in, state_reg == ST_IDLE)
    `GBC_ASSERT_IMPLY(a_start_only_once, clk, rst_n, req.start, !issued_reg)
    `GBC_ASSERT_NEXT(a_result_raises_valid, clk, rst_n, out_load, out_valid_reg)
    `GBC_ASSERT_NEXT(a_done_holds, clk, rst_n,
        state_reg == ST_DONE && out_valid_reg, state_reg == ST_DONE)

endmodule

@@ hw/rtl/gbc_serial_mul.sv @@
// ----------------------------------------------------------------------------
// gbc_serial_mul
// Shift-add signed multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module gbc_serial_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  gbc_pkg::mul_req_t req,
    output gbc_pkg::mul_rsp_t rsp
);
    import gbc_pkg::*;

    localparam int NB = COEF_W + 1;
    localparam int CW = $clog2(NB + 1);

    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0] mcand_reg, mcand_next;
    logic [NB-1:0]            mplier_reg, mplier_next;
    logic [CW-1:0]            count_reg, count_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic signed [PROD_W-1:0] addend;

    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        count_next  = count_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        addend      = '0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = PROD_W'(req.mcand);
            mplier_next = req.mplier;
            count_next  = '0;
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            // the top multiplier bit carries negative weight
            if (mplier_reg[0])
                addend = (count_reg == CW'(NB - 1)) ? -mcand_reg : mcand_reg;
            acc_next    = acc_reg + addend;
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            count_next  = count_reg + 1'b1;
            if (count_reg == CW'(NB - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

endmodule

@@ tb/gammatone_baseband_cascade_filter_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gammatone_baseband_cascade_filter_tb
// Drives audio samples through the filter under random bursts and output
// stalls, and checks every filtered result against a bit-true software
// model of the mixer, the one-pole cascade and the output stage.
// ----------------------------------------------------------------------------
module gammatone_baseband_cascade_filter_tb;
    import gbc_pkg::*;

    localparam int SETTLE_CYCLES = 400;

    typedef struct {
        logic signed [15:0] sample;
        logic               first;
        logic               known;
        logic signed [23:0] filtered;
    } sample_row_t;

    logic clk;
    logic rst_n;

    gbc_in_if  in_ch ();
    gbc_out_if out_ch ();
    gbc_cfg_if cfg ();

    gammatone_baseband_cascade_filter u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    // model state
    int                 sin_tab [TABLE_DEPTH];
    int                 cos_tab [TABLE_DEPTH];
    longint             coef_q16;
    longint             step_turns;
    longint             acc_re [STAGES];
    longint             acc_im [STAGES];
    longint             mix_re_last;
    longint             mix_im_last;
    longint             phase;
    logic signed [23:0] filtered_q [$];
    sample_row_t        known_q [$];
    int                 errs;
    int                 hold_cycles;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int quarter_wave(longint x);
        longint sq;
        longint acc;
        longint r;
        sq  = (x * x) >>> 16;
        acc = 64'sd4858603;
        acc = 64'sd85569278 - ((acc * sq) >>> 16);
        acc = 64'sd693598564 - ((acc * sq) >>> 16);
        acc = 64'sd1686629713 - ((acc * sq) >>> 16);
        r   = (acc * x) >>> 16;
        r   = (r + 16384) >>> 15;
        if (r > 32767) r = 32767;
        if (r < 0) r = 0;
        return int'(r);
    endfunction

    function automatic longint round_down_by(longint v, int sh);
        return (v + (64'sd1 <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        hi = (64'sd1 <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < STAGES; i++)
        begin
            acc_re[i] = 0;
            acc_im[i] = 0;
        end
        mix_re_last = 0;
        mix_im_last = 0;
        phase       = 0;
    endfunction

    function automatic logic signed [23:0] filter_sample(logic signed [15:0] s, logic first);
        longint x;
        longint c;
        longint sn;
        longint mr;
        longint mi;
        longint pr;
        longint pim;
        longint y;
        int     idx;
        x = longint'(s);
        if (first) clear_history();
        idx = int'((phase * TABLE_DEPTH) >>> PHASE_W);
        c   = cos_tab[idx];
        sn  = sin_tab[idx];
        mr  = round_down_by(x * c, 15);
        mi  = -round_down_by(x * sn, 15);
        // last stage first so each stage sees its input's old value
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            pr  = (i == 0) ? mix_re_last : acc_re[i-1];
            pim = (i == 0) ? mix_im_last : acc_im[i-1];
            acc_re[i] = clamp(acc_re[i] + round_down_by(coef_q16 * (pr - acc_re[i]), 16),
                              STATE_W);
            acc_im[i] = clamp(acc_im[i] + round_down_by(coef_q16 * (pim - acc_im[i]), 16),
                              STATE_W);
        end
        mix_re_last = clamp(mr, STATE_W);
        mix_im_last = clamp(mi, STATE_W);
        y = acc_re[STAGES-1] * c - acc_im[STAGES-1] * sn;
        y = clamp(round_down_by(y, 15), 24);
        phase = (phase + step_turns) & ((64'sd1 <<< PHASE_W) - 1);
        return 24'(y);
    endfunction

    initial
    begin
        longint q;
        longint x;
        int     a;
        int     b;
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            q = (longint'(j) * 4) / TABLE_DEPTH;
            x = ((longint'(j) * 4 - q * TABLE_DEPTH) * 65536) / TABLE_DEPTH;
            a = quarter_wave(x);
            b = quarter_wave(65536 - x);
            case (q & 3)
                0:       begin sin_tab[j] = a;  cos_tab[j] = b;  end
                1:       begin sin_tab[j] = b;  cos_tab[j] = -a; end
                2:       begin sin_tab[j] = -a; cos_tab[j] = -b; end
                default: begin sin_tab[j] = -b; cos_tab[j] = a;  end
            endcase
        end
        coef_q16   = 0;
        step_turns = 0;
        clear_history();
    end

    // predict on input items, follow config writes, check results
    always @(posedge clk)
    begin
        logic signed [23:0] want;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == REG_SMOOTHING) coef_q16 = longint'(cfg.data[15:0]);
                else if (cfg.index == REG_PHASE_STEP) step_turns = longint'(cfg.data);
            end
            if (in_ch.valid && in_ch.ready)
                filtered_q.push_back(filter_sample(in_ch.sample, in_ch.first_sample));
            if (out_ch.valid && out_ch.ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("unexpected item: filtered=%0d", out_ch.filtered);
                    errs++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_ch.filtered !== want)
                    begin
                        $error("filtered: expected %0d, actual %0d", want, out_ch.filtered);
                        errs++;
                    end
                    if (known_q.size() > 0 && known_q[0].known)
                    begin
                        if (out_ch.filtered !== known_q[0].filtered)
                        begin
                            $error("filtered: expected %0d, actual %0d",
                                   known_q[0].filtered, out_ch.filtered);
                            errs++;
                        end
                    end
                    if (known_q.size() > 0) void'(known_q.pop_front());
                end
            end
        end
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial
    begin
        int mode;
        out_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles  <= hold_cycles - 1;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 99);
                out_ch.ready <= (mode < 60) ? 1'b1 : ($urandom_range(0, 3) == 0);
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    task automatic send(logic signed [15:0] s, logic first);
        in_ch.valid        <= 1'b1;
        in_ch.sample       <= s;
        in_ch.first_sample <= first;
        do @(posedge clk); while (!in_ch.ready);
    endtask

    // drop valid between bursts; a burst keeps it high
    int burst_left;
    task automatic pace();
        if (burst_left > 0)
            burst_left--;
        else
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (filtered_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_run(int n);
        logic signed [15:0] s;
        int pick;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5) s = 16'sh7FFF;
            else if (pick < 10) s = -16'sh8000;
            else s = 16'($urandom());
            known_q.push_back('{s, 1'b0, 1'b0, 24'sd0});
            send(s, $urandom_range(0, 99) < 3);
            pace();
        end
    endtask

    sample_row_t directed [] = '{
        '{16'sh7FFF, 1'b1, 1'b1, 24'sd0},
        '{-16'sh8000, 1'b0, 1'b0, 24'sd0},
        '{16'sh7FFF, 1'b0, 1'b0, 24'sd0},
        '{16'sh7FFF, 1'b0, 1'b0, 24'sd0},
        '{16'sh0000, 1'b0, 1'b0, 24'sd0},
        '{16'sh0001, 1'b0, 1'b0, 24'sd0},
        '{-16'sh0001, 1'b0, 1'b0, 24'sd0},
        '{16'sh5555, 1'b0, 1'b0, 24'sd0},
        '{-16'sh2AAB, 1'b0, 1'b0, 24'sd0},
        '{-16'sh8000, 1'b1, 1'b1, 24'sd0},
        '{-16'sh8000, 1'b0, 1'b0, 24'sd0},
        '{-16'sh8000, 1'b0, 1'b0, 24'sd0},
        '{-16'sh8000, 1'b0, 1'b0, 24'sd0},
        '{-16'sh8000, 1'b0, 1'b0, 24'sd0},
        '{16'sh7FFF, 1'b0, 1'b0, 24'sd0},
        '{16'sh7FFF, 1'b0, 1'b0, 24'sd0},
        '{16'sh1234, 1'b0, 1'b0, 24'sd0},
        '{16'sh7FFF, 1'b1, 1'b1, 24'sd0},
        '{16'sh7FFF, 1'b0, 1'b0, 24'sd0},
        '{16'sh7FFF, 1'b0, 1'b0, 24'sd0}
    };

    initial
    begin
        errs               = 0;
        hold_cycles        = 0;
        burst_left         = 0;
        rst_n              = 1'b0;
        in_ch.valid        = 1'b0;
        in_ch.sample       = '0;
        in_ch.first_sample = 1'b0;
        cfg.valid          = 1'b0;
        cfg.index          = REG_SMOOTHING;
        cfg.data           = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults from reset: zero coefficient holds the cascade at zero
        for (int k = 0; k < 3; k++)
        begin
            known_q.push_back('{16'sh7FFF, 1'b0, 1'b1, 24'sd0});
            send(16'sh7FFF, k == 0);
        end
        drain();

        // fastest smoothing, quarter-turn phase, upper data bits masked
        write_reg(REG_SMOOTHING, 24'hFFFFFF);
        write_reg(REG_PHASE_STEP, 24'h400000);
        foreach (directed[i])
        begin
            known_q.push_back(directed[i]);
            send(directed[i].sample, directed[i].first);
            pace();
        end
        drain();

        // largest phase step: wraps on every sample but one that starts from phase zero
        write_reg(REG_PHASE_STEP, 24'hFFFFFF);
        write_reg(REG_SMOOTHING, 24'h00FFFF);
        random_run(300);
        // long output hold-off while inputs keep coming
        hold_cycles <= 3000;
        random_run(100);
        drain();

        write_reg(REG_SMOOTHING, 24'h000001);
        write_reg(REG_PHASE_STEP, 24'h000000);
        random_run(250);
        drain();

        for (int p = 0; p < 3; p++)
        begin
            write_reg(REG_SMOOTHING, 24'($urandom()));
            write_reg(REG_PHASE_STEP, 24'($urandom()));
            random_run(180);
            drain();
        end

        if (errs == 0)
            $display("[gammatone_baseband_cascade_filter] OK");
        else
            $display("[gammatone_baseband_cascade_filter] ERROR");
        $finish;
    end

    initial
    begin
        #60ms;
        $display("[gammatone_baseband_cascade_filter] ERROR");
        $finish;
    end

endmodule
